FILE: sv/assert_macros.svh
// Assertion helpers for the basin labeller.
// Each use sits on a line of its own; clk and rst must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high
`define DBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge
`define DBL_ASSERT_NEVER(lbl, cond, msg) \
  `DBL_ASSERT(lbl, !(cond), msg)

`endif

FILE: sv/dbl_pkg.sv
// ----------------------------------------------------------------------------
// dbl_pkg
// Shared types and constants of the descent basin labeller: transfer
// payloads, grid geometry and operation / register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dbl_pkg;

  // Fixed field widths
  localparam int LABEL_W   = 13;
  localparam int INDEX_W   = 12;
  localparam int ELEV_W    = 16;
  localparam int GRID_W    = 7;
  localparam int TOTAL_W   = 2 * GRID_W;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [LABEL_W-1:0] LABEL_SAT   = '1;
  localparam logic [GRID_W-1:0]  GRID_RESET  = 7'd64;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Register indexes (paddr bit 2)
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  // Input item
  typedef struct packed {
    logic                     operation;
    logic [INDEX_W-1:0]       cell_index;
    logic signed [ELEV_W-1:0] elevation;
    logic                     last_load;
  } dbl_in_t;

  // Result item
  typedef struct packed {
    logic [LABEL_W-1:0] basin_label;
    logic               is_minimum;
    logic [LABEL_W-1:0] basin_count;
  } dbl_out_t;

  // Grid geometry in use, clamped to the legal range
  typedef struct packed {
    logic [GRID_W-1:0]  rows;
    logic [GRID_W-1:0]  cols;
    logic [TOTAL_W-1:0] total;
  } dbl_geom_t;

endpackage

`default_nettype wire

FILE: sv/descent_basin_labeler.sv
// ----------------------------------------------------------------------------
// descent_basin_labeler
// Watershed labelling of a signed elevation grid by steepest descent.
// ----------------------------------------------------------------------------
// Loads are taken one per cycle while idle; a read is taken, its label
// word is fetched, the result moves into the output register in
// S_READ_WAIT, and the next item is taken after that. A result still
// waiting in the output register holds the following read until that
// result is transferred. A load marked last starts the labelling
// pass, during which no item is taken: a clearing sweep of the label
// memory, then for each cell in raster order a descent walk in which
// each step reads the cell and then sweeps its neighbours one read at a
// time, ending when the walk meets a labelled cell, then a new-basin
// write at a minimum, a write of the start cell and a scan step. The
// single read port of the elevation memory sets the step cost. After
// reset the same clearing sweep runs before the first item is taken;
// register writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module descent_basin_labeler #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Item channel
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire dbl_pkg::dbl_in_t             req,
  // Result channel
  output logic                              rsp_valid,
  input  wire logic                         rsp_ready,
  output dbl_pkg::dbl_out_t                 rsp,
  // Register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dbl_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [dbl_pkg::PDATA_W-1:0]  pwdata,
  output logic      [dbl_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  dbl_pkg::dbl_geom_t geom;

  // Grid geometry registers
  dbl_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom)
  );

  // Memories and labelling sequencer
  dbl_core #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Checks
  `DBL_ASSERT(a_read_holds_off, (req_valid && req_ready && req.operation == dbl_pkg::OP_READ) |=> !req_ready, "item taken while a read is in flight")
  `DBL_ASSERT(a_pass_holds_off, (req_valid && req_ready && req.operation == dbl_pkg::OP_LOAD && req.last_load) |=> !req_ready, "item taken at start of labelling pass")
  `DBL_ASSERT(a_rsp_from_read, $rose(rsp_valid) |-> !$past(req_ready), "result raised without a pending read")
  `DBL_ASSERT_NEVER(a_min_labelled, rsp_valid && rsp.is_minimum && rsp.basin_label == '0, "minimum reported without a label")

endmodule

`default_nettype wire

FILE: sv/dbl_cfg.sv
// ----------------------------------------------------------------------------
// dbl_cfg
// APB register block for grid_rows / grid_cols. Clamps the written values
// to the legal range and derives the number of cells in use.
// ----------------------------------------------------------------------------
`default_nettype none

module dbl_cfg #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dbl_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [dbl_pkg::PDATA_W-1:0]  pwdata,
  output logic      [dbl_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output dbl_pkg::dbl_geom_t                geom
);

  logic [dbl_pkg::GRID_W-1:0] grid_rows;
  logic [dbl_pkg::GRID_W-1:0] grid_cols;
  logic                       reg_sel;
  logic                       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= dbl_pkg::GRID_RESET;
      grid_cols <= dbl_pkg::GRID_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        dbl_pkg::REG_GRID_ROWS: grid_rows <= pwdata[dbl_pkg::GRID_W-1:0];
        dbl_pkg::REG_GRID_COLS: grid_cols <= pwdata[dbl_pkg::GRID_W-1:0];
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (reg_sel)
      dbl_pkg::REG_GRID_ROWS: prdata = dbl_pkg::PDATA_W'(grid_rows);
      dbl_pkg::REG_GRID_COLS: prdata = dbl_pkg::PDATA_W'(grid_cols);
    endcase
  end

  // Clamp: zero is used as one, above the maximum is used as the maximum
  always_comb begin
    if (grid_rows == '0)
      geom.rows = dbl_pkg::GRID_W'(1);
    else if (32'(grid_rows) > MAX_ROWS)
      geom.rows = dbl_pkg::GRID_W'(MAX_ROWS);
    else
      geom.rows = grid_rows;

    if (grid_cols == '0)
      geom.cols = dbl_pkg::GRID_W'(1);
    else if (32'(grid_cols) > MAX_COLS)
      geom.cols = dbl_pkg::GRID_W'(MAX_COLS);
    else
      geom.cols = grid_cols;

    geom.total = dbl_pkg::TOTAL_W'(geom.rows) * dbl_pkg::TOTAL_W'(geom.cols);
  end

endmodule

`default_nettype wire

FILE: sv/dbl_core.sv
// ----------------------------------------------------------------------------
// dbl_core
// Elevation and label memories with the sequencer that serves loads and
// reads and runs the labelling pass: clearing sweep, raster scan and
// steepest-descent walks with a one-read-per-cycle neighbour sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module dbl_core #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dbl_pkg::dbl_geom_t geom,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire dbl_pkg::dbl_in_t   req,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output dbl_pkg::dbl_out_t       rsp
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (AW > dbl_pkg::INDEX_W) ? AW : dbl_pkg::INDEX_W;
  localparam int GW    = dbl_pkg::GRID_W;
  localparam int LW    = dbl_pkg::LABEL_W;
  localparam logic [3:0] NB_DONE = 4'd8;

  typedef struct packed {
    logic          minimum;
    logic [LW-1:0] label;
  } lbl_word_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ_WAIT,
    S_WALK_READ,
    S_NEIGH,
    S_MIN_WRITE,
    S_START_WRITE,
    S_NEXT_SCAN
  } state_t;

  // Neighbour k in row-major order: 0..2 row above, 3..4 same row, 5..7 below
  function automatic logic nb_up(input logic [2:0] k);
    return k < 3'd3;
  endfunction

  function automatic logic nb_down(input logic [2:0] k);
    return k > 3'd4;
  endfunction

  function automatic logic nb_left(input logic [2:0] k);
    return (k == 3'd0) || (k == 3'd3) || (k == 3'd5);
  endfunction

  function automatic logic nb_right(input logic [2:0] k);
    return (k == 3'd2) || (k == 3'd4) || (k == 3'd7);
  endfunction

  function automatic logic [AW-1:0] step_addr(input logic [AW-1:0] a,
                                              input logic [AW-1:0] c,
                                              input logic [2:0]    k);
    logic [AW-1:0] rb;
    rb = nb_up(k) ? (a - c) : (nb_down(k) ? (a + c) : a);
    if (nb_left(k))
      return rb - AW'(1);
    else if (nb_right(k))
      return rb + AW'(1);
    else
      return rb;
  endfunction

  // Memories
  logic [dbl_pkg::ELEV_W-1:0] elev_mem [DEPTH];
  lbl_word_t                  lbl_mem  [DEPTH];

  logic                       elev_we;
  logic [AW-1:0]              elev_waddr;
  logic [dbl_pkg::ELEV_W-1:0] elev_wdata;
  logic [AW-1:0]              elev_raddr;
  logic [dbl_pkg::ELEV_W-1:0] elev_rdata;

  logic                       lbl_we;
  logic [AW-1:0]              lbl_waddr;
  lbl_word_t                  lbl_wdata;
  logic                       lbl_re;
  logic [AW-1:0]              lbl_raddr;
  lbl_word_t                  lbl_rdata;

  // Control state
  state_t                     state;
  logic                       pass_pending;
  logic [AW-1:0]              clr_addr;
  logic [AW-1:0]              scan_addr;
  logic [GW-1:0]              scan_row;
  logic [GW-1:0]              scan_col;
  logic [AW-1:0]              cur_addr;
  logic [GW-1:0]              cur_row;
  logic [GW-1:0]              cur_col;
  logic [3:0]                 cnt;
  logic                       nb_inb;
  logic [2:0]                 nb_k;
  logic signed [dbl_pkg::ELEV_W-1:0] best;
  logic [2:0]                 best_k;
  logic                       moved;
  logic [LW-1:0]              lab;
  logic [LW-1:0]              next_basin;
  logic                       rd_in_range;
  logic                       out_valid;
  dbl_pkg::dbl_out_t          out_data;

  // Decoded request
  logic                       accept;
  logic                       in_range;
  logic [IW-1:0]              idx_w;
  logic [AW-1:0]              idx_a;

  // Neighbour sweep
  logic [2:0]                 k_now;
  logic [AW-1:0]              cols_a;
  logic                       inb;
  logic [AW-1:0]              nb_addr;
  logic signed [dbl_pkg::ELEV_W-1:0] elev_s;
  logic signed [dbl_pkg::ELEV_W-1:0] cand_best;
  logic [2:0]                 cand_k;
  logic                       cand_moved;
  logic                       scan_last;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign idx_w     = IW'(req.cell_index);
  assign idx_a     = idx_w[AW-1:0];
  assign in_range  = {2'b00, req.cell_index} < geom.total;
  assign rsp_valid = out_valid;
  assign rsp       = out_data;

  assign k_now     = cnt[2:0];
  assign cols_a    = AW'(geom.cols);
  assign elev_s    = elev_rdata;
  assign scan_last = (scan_row == geom.rows - GW'(1)) && (scan_col == geom.cols - GW'(1));

  // Bounds and address of the neighbour read issued this cycle
  always_comb begin
    inb = 1'b1;
    if (nb_up(k_now) && (cur_row == '0))                     inb = 1'b0;
    if (nb_down(k_now) && (cur_row == geom.rows - GW'(1)))   inb = 1'b0;
    if (nb_left(k_now) && (cur_col == '0))                   inb = 1'b0;
    if (nb_right(k_now) && (cur_col == geom.cols - GW'(1)))  inb = 1'b0;
    nb_addr = step_addr(cur_addr, cols_a, k_now);
  end

  // Running minimum over the data returned this cycle
  always_comb begin
    cand_best  = best;
    cand_k     = best_k;
    cand_moved = moved;
    if (cnt == '0) begin
      cand_best  = elev_s;
      cand_k     = '0;
      cand_moved = 1'b0;
    end else if (nb_inb && (elev_s < best)) begin
      cand_best  = elev_s;
      cand_k     = nb_k;
      cand_moved = 1'b1;
    end
  end

  // Memory port steering
  always_comb begin
    elev_we    = (state == S_IDLE) && accept && (req.operation == dbl_pkg::OP_LOAD)
                 && in_range;
    elev_waddr = idx_a;
    elev_wdata = req.elevation;
    elev_raddr = (state == S_NEIGH) ? nb_addr : cur_addr;

    lbl_re     = ((state == S_IDLE) && accept) || (state == S_WALK_READ);
    lbl_raddr  = (state == S_IDLE) ? idx_a : cur_addr;

    lbl_we     = 1'b0;
    lbl_waddr  = clr_addr;
    lbl_wdata  = '0;
    unique case (state)
      S_CLEAR: begin
        lbl_we = 1'b1;
      end
      S_MIN_WRITE: begin
        lbl_we    = 1'b1;
        lbl_waddr = cur_addr;
        lbl_wdata = '{minimum: 1'b1, label: next_basin};
      end
      S_START_WRITE: begin
        lbl_we    = 1'b1;
        lbl_waddr = scan_addr;
        lbl_wdata = '{minimum: 1'b0, label: lab};
      end
      default: begin
        lbl_we = 1'b0;
      end
    endcase
  end

  // Elevation memory
  always_ff @(posedge clk) begin
    if (elev_we)
      elev_mem[elev_waddr] <= elev_wdata;
    elev_rdata <= elev_mem[elev_raddr];
  end

  // Label memory
  always_ff @(posedge clk) begin
    if (lbl_we)
      lbl_mem[lbl_waddr] <= lbl_wdata;
    if (lbl_re)
      lbl_rdata <= lbl_mem[lbl_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      pass_pending <= 1'b0;
      clr_addr     <= '0;
      scan_addr    <= '0;
      scan_row     <= '0;
      scan_col     <= '0;
      cur_addr     <= '0;
      cur_row      <= '0;
      cur_col      <= '0;
      cnt          <= '0;
      next_basin   <= LW'(1);
      out_valid    <= 1'b0;
    end else begin
      // Result register: filled by a finished read, emptied by a transfer
      if ((state == S_READ_WAIT) && (!out_valid || rsp_ready))
        out_valid <= 1'b1;
      else if (out_valid && rsp_ready)
        out_valid <= 1'b0;

      unique case (state)
        // Sweep the label memory to zero
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            clr_addr <= '0;
            if (pass_pending) begin
              pass_pending <= 1'b0;
              next_basin   <= LW'(1);
              scan_addr    <= '0;
              scan_row     <= '0;
              scan_col     <= '0;
              cur_addr     <= '0;
              cur_row      <= '0;
              cur_col      <= '0;
              state        <= S_WALK_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        // Loads and reads
        S_IDLE: begin
          if (accept) begin
            if (req.operation == dbl_pkg::OP_READ) begin
              rd_in_range <= in_range;
              state       <= S_READ_WAIT;
            end else if (req.last_load) begin
              pass_pending <= 1'b1;
              clr_addr     <= '0;
              state        <= S_CLEAR;
            end
          end
        end

        // Label data is back; move it to the output register once free
        S_READ_WAIT: begin
          if (!out_valid || rsp_ready) begin
            out_data.basin_label <= rd_in_range ? lbl_rdata.label : '0;
            out_data.is_minimum  <= rd_in_range && lbl_rdata.minimum;
            out_data.basin_count <= next_basin - LW'(1);
            state                <= S_IDLE;
          end
        end

        // Fetch label and elevation of the current walk cell
        S_WALK_READ: begin
          cnt   <= '0;
          state <= S_NEIGH;
        end

        // One neighbour read per cycle, compared in the next cycle
        S_NEIGH: begin
          best   <= cand_best;
          best_k <= cand_k;
          moved  <= cand_moved;
          nb_inb <= inb;
          nb_k   <= k_now;
          cnt    <= cnt + 4'd1;
          if ((cnt == '0) && (lbl_rdata.label != '0)) begin
            lab   <= lbl_rdata.label;
            state <= (cur_addr == scan_addr) ? S_NEXT_SCAN : S_START_WRITE;
          end else if (cnt == NB_DONE) begin
            if (!cand_moved) begin
              state <= S_MIN_WRITE;
            end else begin
              cur_addr <= step_addr(cur_addr, cols_a, cand_k);
              cur_row  <= nb_up(cand_k) ? (cur_row - GW'(1))
                        : (nb_down(cand_k) ? (cur_row + GW'(1)) : cur_row);
              cur_col  <= nb_left(cand_k) ? (cur_col - GW'(1))
                        : (nb_right(cand_k) ? (cur_col + GW'(1)) : cur_col);
              state    <= S_WALK_READ;
            end
          end
        end

        // New basin at a local minimum
        S_MIN_WRITE: begin
          lab <= next_basin;
          if (next_basin != dbl_pkg::LABEL_SAT)
            next_basin <= next_basin + LW'(1);
          state <= (cur_addr == scan_addr) ? S_NEXT_SCAN : S_START_WRITE;
        end

        // Label the start cell of the walk
        S_START_WRITE: begin
          state <= S_NEXT_SCAN;
        end

        // Advance the raster scan
        S_NEXT_SCAN: begin
          if (scan_last) begin
            scan_addr <= '0;
            scan_row  <= '0;
            scan_col  <= '0;
            cur_addr  <= '0;
            cur_row   <= '0;
            cur_col   <= '0;
            state     <= S_IDLE;
          end else begin
            scan_addr <= scan_addr + AW'(1);
            cur_addr  <= scan_addr + AW'(1);
            if (scan_col == geom.cols - GW'(1)) begin
              scan_col <= '0;
              scan_row <= scan_row + GW'(1);
              cur_col  <= '0;
              cur_row  <= scan_row + GW'(1);
            end else begin
              scan_col <= scan_col + GW'(1);
              cur_col  <= scan_col + GW'(1);
              cur_row  <= scan_row;
            end
            state <= S_WALK_READ;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/descent_basin_labeler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descent_basin_labeler_tb
// Self-checking bench for the basin labeller. Elevation grids of many shapes
// are loaded, labelling passes are started, and label reads are compared
// field by field with a steepest-descent predictor kept inside the bench.
// Both channels idle at random, and the result side holds off once for a long
// stretch so that the block backs up.
// ----------------------------------------------------------------------------

module descent_basin_labeler_tb;

  localparam int GRID_MAX_ROWS = 64;
  localparam int GRID_MAX_COLS = 64;
  localparam int CELLS         = GRID_MAX_ROWS * GRID_MAX_COLS;
  localparam int BASIN_CAP     = 8191;
  localparam int IDLE_PCT      = 7;
  localparam int HOLD_CYCLES   = 400;
  localparam int ITEM_TARGET   = 740;
  localparam int ITEM_CYCLES   = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 64;
  localparam int MAX_PRINTED   = 40;

  typedef enum int unsigned {ELEV_FULL, ELEV_NARROW, ELEV_EXTREME, ELEV_RAMP} elev_style_e;

  // A result still owed by the block, with the cell it was read from
  typedef struct {
    dbl_pkg::dbl_out_t           result;
    logic [dbl_pkg::INDEX_W-1:0] pos;
  } label_due_t;

  // Clock, reset and block ports
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          req_valid = 1'b0;
  logic                          req_ready;
  dbl_pkg::dbl_in_t              req       = '0;
  logic                          rsp_valid;
  logic                          rsp_ready = 1'b0;
  dbl_pkg::dbl_out_t             rsp;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [dbl_pkg::PADDR_W-1:0]   paddr     = '0;
  logic [dbl_pkg::PDATA_W-1:0]   pwdata    = '0;
  logic [dbl_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  // Predictor state: own copy of the grid, labels and registers
  logic signed [dbl_pkg::ELEV_W-1:0] elev_mem  [CELLS];
  logic [dbl_pkg::LABEL_W-1:0]       label_mem [CELLS];
  bit                                min_mem   [CELLS];
  int unsigned                       basin_next = 1;
  logic [dbl_pkg::GRID_W-1:0]        rows_reg   = dbl_pkg::GRID_RESET;
  logic [dbl_pkg::GRID_W-1:0]        cols_reg   = dbl_pkg::GRID_RESET;

  // Stimulus bookkeeping
  dbl_pkg::dbl_in_t items_pending[$];
  label_due_t   label_reads_due[$];
  bit           loaded [CELLS];
  int unsigned  items_queued   = 0;
  int unsigned  items_sent     = 0;
  int unsigned  reads_checked  = 0;
  int unsigned  passes_run     = 0;
  int unsigned  settings_made  = 0;
  int unsigned  mismatch_count = 0;
  longint       cycle_budget   = CELLS + 100 + HOLD_CYCLES;
  longint       cycle_count    = 0;
  bit           hold_wanted    = 1'b0;
  int           hold_left      = -1;

  descent_basin_labeler #(
    .MAX_ROWS(GRID_MAX_ROWS),
    .MAX_COLS(GRID_MAX_COLS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      elev_mem[i]  = '0;
      label_mem[i] = '0;
      min_mem[i]   = 1'b0;
      loaded[i]    = 1'b0;
    end
  end

  // Geometry in use, with out-of-range register values clamped
  function automatic int unsigned used_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > GRID_MAX_ROWS) return GRID_MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic int unsigned used_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > GRID_MAX_COLS) return GRID_MAX_COLS;
    return cols_reg;
  endfunction

  // Stretch of the run with no idling on either side
  function automatic bit steady_window();
    return items_sent >= 300 && items_sent < 450;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Steepest-descent labelling of the grid; returns the neighbour sweeps done
  function automatic int unsigned label_basins();
    int unsigned n_rows, n_cols, total, sweeps, pos, best_pos, lab, r, c, p;
    int          best, nr, nc;
    bit          done;
    n_rows = used_rows();
    n_cols = used_cols();
    total  = n_rows * n_cols;
    sweeps = 0;
    for (int i = 0; i < CELLS; i++) begin
      label_mem[i] = '0;
      min_mem[i]   = 1'b0;
    end
    basin_next = 1;
    for (int unsigned s = 0; s < total; s++) begin
      pos  = s;
      done = 1'b0;
      lab  = 0;
      while (!done) begin
        if (label_mem[pos] != 0) begin
          // walk reached a labelled cell
          lab  = label_mem[pos];
          done = 1'b1;
        end else begin
          r        = pos / n_cols;
          c        = pos % n_cols;
          best     = elev_mem[pos];
          best_pos = pos;
          sweeps++;
          // lowest strictly lower neighbour, first in raster order on ties
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              nr = int'(r) + dr;
              nc = int'(c) + dc;
              if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 &&
                  nr < int'(n_rows) && nc < int'(n_cols)) begin
                p = nr * n_cols + nc;
                if (elev_mem[p] < best) begin
                  best     = elev_mem[p];
                  best_pos = p;
                end
              end
            end
          end
          if (best_pos == pos) begin
            // local minimum opens a new basin
            lab            = basin_next;
            label_mem[pos] = dbl_pkg::LABEL_W'(lab);
            min_mem[pos]   = 1'b1;
            if (basin_next < BASIN_CAP) basin_next++;
            done = 1'b1;
          end else begin
            pos = best_pos;
          end
        end
      end
      label_mem[s] = dbl_pkg::LABEL_W'(lab);
    end
    return sweeps;
  endfunction

  // Apply one accepted item to the predictor
  task automatic predict_item(input dbl_pkg::dbl_in_t item);
    int unsigned total;
    label_due_t  due;
    total = used_rows() * used_cols();
    cycle_budget += ITEM_CYCLES;
    if (item.operation == dbl_pkg::OP_LOAD) begin
      if (item.cell_index < total) elev_mem[item.cell_index] = item.elevation;
      if (item.last_load) begin
        cycle_budget += CELLS + 5 * total + 10 * label_basins();
        passes_run++;
      end
    end else begin
      due.pos                = item.cell_index;
      due.result.basin_count = dbl_pkg::LABEL_W'(basin_next - 1);
      if (item.cell_index < total) begin
        due.result.basin_label = label_mem[item.cell_index];
        due.result.is_minimum  = min_mem[item.cell_index];
      end else begin
        due.result.basin_label = '0;
        due.result.is_minimum  = 1'b0;
      end
      label_reads_due.insert(label_reads_due.size(), due);
    end
  endtask

  // Item driver: presents pending items and predicts each transfer
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        predict_item(req);
        items_sent++;
      end
      if (!req_valid || req_ready) begin
        if (items_pending.size() != 0 &&
            (steady_window() || $urandom_range(99) >= IDLE_PCT)) begin
          req       <= items_pending.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random idling plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_wanted && hold_left < 0) begin
      hold_left = HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= steady_window() || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result monitor: each transfer against the oldest owed result
  always @(posedge clk) begin : result_check
    label_due_t due;
    if (!rst && rsp_valid && rsp_ready) begin
      if (label_reads_due.size() == 0) begin
        report_mismatch($sformatf("result with none owed: label %0d min %0d count %0d",
                                  rsp.basin_label, rsp.is_minimum, rsp.basin_count));
      end else begin
        due = label_reads_due.pop_front();
        reads_checked++;
        if (rsp.basin_label !== due.result.basin_label)
          report_mismatch($sformatf("pos %0d basin_label %0d, want %0d", due.pos,
                                    rsp.basin_label, due.result.basin_label));
        if (rsp.is_minimum !== due.result.is_minimum)
          report_mismatch($sformatf("pos %0d is_minimum %0d, want %0d", due.pos,
                                    rsp.is_minimum, due.result.is_minimum));
        if (rsp.basin_count !== due.result.basin_count)
          report_mismatch($sformatf("pos %0d basin_count %0d, want %0d", due.pos,
                                    rsp.basin_count, due.result.basin_count));
      end
    end
  end

  // Run limit, grown with the predicted work
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 4 * cycle_budget + 20000) begin
      $display("[%0t] timeout after %0d cycles", $time, cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_item(input logic op, input int unsigned pos,
                           input logic [dbl_pkg::ELEV_W-1:0] elev, input logic last);
    dbl_pkg::dbl_in_t item;
    item.operation  = op;
    item.cell_index = dbl_pkg::INDEX_W'(pos);
    item.elevation  = elev;
    item.last_load  = last;
    if (op == dbl_pkg::OP_LOAD && pos < used_rows() * used_cols()) loaded[pos] = 1'b1;
    items_pending.insert(items_pending.size(), item);
    items_queued++;
  endtask

  // Wait until every item is taken and every result has come back
  task automatic drain_to_idle();
    do @(posedge clk);
    while (items_pending.size() != 0 || req_valid || label_reads_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write followed by a read back of the same register
  task automatic write_and_check(input logic sel, input logic [dbl_pkg::GRID_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= dbl_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (sel == dbl_pkg::REG_GRID_ROWS) rows_reg = value;
    else cols_reg = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== dbl_pkg::PDATA_W'(value))
      report_mismatch($sformatf("register %0d reads %0h, want %0h", sel, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_geometry(input logic [dbl_pkg::GRID_W-1:0] n_rows,
                                input logic [dbl_pkg::GRID_W-1:0] n_cols);
    write_and_check(dbl_pkg::REG_GRID_ROWS, n_rows);
    write_and_check(dbl_pkg::REG_GRID_COLS, n_cols);
    settings_made++;
    cycle_budget += 40;
  endtask

  function automatic int unsigned oor_index(input int unsigned total);
    return $urandom_range(CELLS - 1, total);
  endfunction

  function automatic logic [dbl_pkg::ELEV_W-1:0] pick_elev(input elev_style_e style,
                                                           input int unsigned pos,
                                                           input int unsigned n_cols);
    case (style)
      ELEV_FULL:   return dbl_pkg::ELEV_W'($urandom);
      ELEV_NARROW: return dbl_pkg::ELEV_W'(int'($urandom_range(6)) - 3);
      ELEV_EXTREME: begin
        case ($urandom_range(3))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h8001;
          default: return dbl_pkg::ELEV_W'($urandom);
        endcase
      end
      default:
        // sloping grid with a little noise: long walks towards one corner
        return dbl_pkg::ELEV_W'(int'(pos / n_cols + pos % n_cols) * 64 - 2000 +
                                int'($urandom_range(1)));
    endcase
  endfunction

  // Stimulus
  initial begin : stimulus
    logic signed [dbl_pkg::ELEV_W-1:0] dir_elev [6];
    logic [dbl_pkg::GRID_W-1:0]        rows_val, cols_val;
    int unsigned              phase, total, n_cols, n_reads, pick, j, swap_tmp;
    int unsigned              load_list[$];
    bit                       reload_all, with_pass, oor_last;
    elev_style_e              style;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reads at the reset geometry, before any pass; last_load on a read
    push_item(dbl_pkg::OP_READ, 0, 16'h0000, 1'b0);
    push_item(dbl_pkg::OP_READ, CELLS - 1, 16'hFFFF, 1'b1);
    push_item(dbl_pkg::OP_READ, 100, 16'h0000, 1'b0);
    drain_to_idle();

    // 2x3 grid with both extremes and tied minima
    write_geometry(2, 3);
    dir_elev = '{16'sd5, 16'sh8000, 16'sd5, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
    for (int i = 0; i < 6; i++) push_item(dbl_pkg::OP_LOAD, i, dir_elev[i], 1'b0);
    // load out of range writes nothing; the last one still starts the pass
    push_item(dbl_pkg::OP_LOAD, CELLS - 1, 16'h0000, 1'b0);
    push_item(dbl_pkg::OP_LOAD, 6, 16'h1234, 1'b1);
    for (int i = 0; i < 7; i++) push_item(dbl_pkg::OP_READ, i, 16'h0000, 1'b0);
    push_item(dbl_pkg::OP_READ, CELLS - 1, 16'h0000, 1'b1);
    drain_to_idle();

    // Result side holds off while reads keep coming, so the block backs up
    hold_wanted = 1'b1;
    for (int i = 0; i < 30; i++)
      push_item(dbl_pkg::OP_READ, $urandom_range(7), dbl_pkg::ELEV_W'($urandom),
                1'($urandom_range(1)));
    drain_to_idle();

    // Random phases: mostly full loads and a pass, with noise mixed in
    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      case (phase)
        0: begin rows_val = 64;  cols_val = 1;   end
        1: begin rows_val = 1;   cols_val = 64;  end
        2: begin rows_val = 0;   cols_val = 127; end
        3: begin rows_val = 100; cols_val = 0;   end
        default: begin
          pick = $urandom_range(9);
          if (pick == 0) begin
            rows_val = $urandom_range(16, 10);
            cols_val = $urandom_range(16, 10);
          end else if (pick == 1) begin
            rows_val = 1;
            cols_val = 1;
          end else begin
            rows_val = $urandom_range(8, 1);
            cols_val = $urandom_range(8, 1);
          end
        end
      endcase
      // now and then keep the geometry, so old elevations are reused
      if (phase < 4 || $urandom_range(4) != 0) write_geometry(rows_val, cols_val);
      n_cols = used_cols();
      total  = used_rows() * n_cols;

      // every cell of the pass must hold an elevation
      load_list.delete();
      reload_all = ($urandom_range(1) == 0);
      for (int unsigned i = 0; i < total; i++)
        if (!loaded[i] || reload_all || $urandom_range(2) == 0)
          load_list.insert(load_list.size(), i);
      if ($urandom_range(1) == 1) begin
        for (int i = load_list.size() - 1; i > 0; i--) begin
          j            = $urandom_range(i);
          swap_tmp     = load_list[i];
          load_list[i] = load_list[j];
          load_list[j] = swap_tmp;
        end
      end

      style     = elev_style_e'($urandom_range(3));
      with_pass = ($urandom_range(5) != 0);
      oor_last  = ($urandom_range(3) == 0) || load_list.size() == 0;
      foreach (load_list[k]) begin
        if ($urandom_range(9) == 0)
          push_item(dbl_pkg::OP_READ, $urandom_range(total - 1), dbl_pkg::ELEV_W'($urandom),
                    1'($urandom_range(1)));
        if ($urandom_range(19) == 0)
          push_item(dbl_pkg::OP_LOAD, oor_index(total), dbl_pkg::ELEV_W'($urandom), 1'b0);
        push_item(dbl_pkg::OP_LOAD, load_list[k], pick_elev(style, load_list[k], n_cols),
                  with_pass && !oor_last && k == load_list.size() - 1);
      end
      if (with_pass && oor_last)
        push_item(dbl_pkg::OP_LOAD, oor_index(total), dbl_pkg::ELEV_W'($urandom), 1'b1);

      // phase always ends on reads, so the block is idle once they return
      n_reads = 6 + $urandom_range(14);
      for (int unsigned i = 0; i < n_reads; i++) begin
        if ($urandom_range(99) < 85)
          push_item(dbl_pkg::OP_READ, $urandom_range(total - 1), dbl_pkg::ELEV_W'($urandom),
                    1'($urandom_range(1)));
        else
          push_item(dbl_pkg::OP_READ, oor_index(total), dbl_pkg::ELEV_W'($urandom),
                    1'($urandom_range(1)));
      end
      drain_to_idle();
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (label_reads_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", label_reads_due.size()));

    $display("Run covered %0d items and %0d checked label reads over %0d labelling passes",
             items_sent, reads_checked, passes_run);
    $display("and %0d grid settings, from 1x1 to 64-long strips, clamped register values included",
             settings_made);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
